@@ hw/rtl/mbr_pkg.sv @@
// mbr_pkg: shared types and constants for the motor bus route and round-robin unit
// no dependencies; used by mbr_match, mbr_table and the top level
package mbr_pkg;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_FEEDBACK   = 2'd2,
    REQ_UPDATE     = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_REG   = 3'd3,
    ST_NO_MATCH  = 3'd4
  } status_t;

  localparam logic [3:0] FULL_FRAME_LEN = 4'd8;
  localparam logic [4:0] MAX_BUDGET     = 5'd16;
  localparam logic [4:0] BUDGET_RESET   = 5'd1;

  // one table entry, stored as one memory word
  typedef struct packed {
    logic [7:0]  handle;
    logic [28:0] feedback_id;
    logic [3:0]  nibble;
    logic [28:0] transmit_id;
  } entry_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  motor_handle;
    logic [28:0] can_id;
    logic [3:0]  master_nibble;
    logic [28:0] transmit_id;
    logic [3:0]  frame_length;
    logic [7:0]  frame_first_byte;
  } request_t;

  typedef struct packed {
    logic duplicate;
    logic handle_eq;
    logic feedback_hit;
  } match_t;

  // result word, status in the lowest bits
  typedef struct packed {
    logic [15:0] unknown_total;
    logic [7:0]  selected_handle;
    logic [3:0]  slot_index;
    logic        has_motor;
    status_t     status;
  } out_word_t;

endpackage

@@ hw/rtl/mbr_match.sv @@
// mbr_match: compare unit for the table search walk
// depends on mbr_pkg
module mbr_match (
  input  mbr_pkg::request_t req,
  input  mbr_pkg::entry_t   entry,
  output mbr_pkg::match_t   result
);

  logic fb_key_eq;

  assign fb_key_eq = (entry.feedback_id == req.can_id);

  assign result.handle_eq = (entry.handle == req.motor_handle);
  assign result.duplicate = result.handle_eq
                         || (fb_key_eq && entry.nibble == req.master_nibble)
                         || (entry.transmit_id == req.transmit_id);
  assign result.feedback_hit = fb_key_eq
                            && req.frame_length == mbr_pkg::FULL_FRAME_LEN
                            && req.frame_first_byte[3:0] == entry.nibble;

endmodule

@@ hw/rtl/mbr_table.sv @@
// mbr_table: motor table memory, one write port and one registered read port
// depends on mbr_pkg for the entry layout
module mbr_table #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  mbr_pkg::entry_t wr_data,
  input  logic [IW-1:0]   rd_addr,
  output mbr_pkg::entry_t rd_data
);

  mbr_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/motor_bus_route_and_round_robin_unit.sv @@
// motor_bus_route_and_round_robin_unit: sequencer, counters and output register
// depends on mbr_pkg, mbr_match and mbr_table
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser request kind, s_tdata request fields
//  m_*     | out | m_tvalid/m_tready  | m_tdata result word, m_tlast last result
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data transmit budget
//
// s_tready is high only when the sequencer is idle. a table walk reads one entry a
// cycle through the single memory read port and keeps s_tready low until it ends; a
// hit ends it early. unregister then moves each later entry down by one slot. an
// update tick emits one result word per serviced motor (one word when none is serviced).
// reset clears the counters and pointer, the table contents are not cleared.
// results wait in the output register while m_tready is low; the sequencer holds.
module motor_bus_route_and_round_robin_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // motor_handle, can_id, master_nibble, transmit_id,
                                // frame_length, frame_first_byte, zero pad
  input  logic [1:0]  s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // status, has_motor, slot_index, selected_handle,
                                // unknown_total
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP,
    S_UPD_START,
    S_UPD_RD,
    S_UPD_EMIT
  } state_t;

  state_t              state;
  mbr_pkg::request_t   req;
  logic [CW-1:0]       count;
  logic [IW-1:0]       ptr;
  logic [15:0]         unknown;
  logic [4:0]          budget;
  logic [CW-1:0]       idx;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic                sh_vld;
  logic [IW-1:0]       sh_idx;
  logic [4:0]          rem;
  mbr_pkg::status_t    res_status;
  logic                res_has;
  logic [IW-1:0]       res_slot;
  logic [7:0]          res_handle;
  mbr_pkg::out_word_t  out_word;

  logic                out_free;
  logic                out_load;
  logic [CW-1:0]       idx_p1;
  logic [CW-1:0]       ptr_ext;
  logic                hit;
  logic                scan_done;
  logic [4:0]          bud_sat;
  logic [4:0]          rem_calc;
  logic [IW-1:0]       emit_slot;
  logic [IW+3:0]       slot_wide;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  mbr_pkg::entry_t     wr_data;
  mbr_pkg::entry_t     rd_data;
  mbr_pkg::entry_t     new_entry;
  mbr_pkg::match_t     match;

  mbr_match u_match (
    .req    (req),
    .entry  (rd_data),
    .result (match)
  );

  mbr_table #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_word;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (state == S_RESP || state == S_UPD_EMIT);

  assign idx_p1    = idx + CW'(1);
  assign ptr_ext   = CW'(ptr);
  assign scan_done = !cmp_vld && (idx >= count);
  assign bud_sat   = (budget > mbr_pkg::MAX_BUDGET) ? mbr_pkg::MAX_BUDGET : budget;
  assign rem_calc  = (CMPW'(count) < CMPW'(bud_sat)) ? 5'(count) : bud_sat;
  assign emit_slot = (state == S_UPD_EMIT) ? ptr : res_slot;
  assign slot_wide = {4'b0000, emit_slot};

  assign new_entry.handle      = req.motor_handle;
  assign new_entry.feedback_id = req.can_id;
  assign new_entry.nibble      = req.master_nibble;
  assign new_entry.transmit_id = req.transmit_id;

  always_comb begin
    case (req.kind)
      mbr_pkg::REQ_REGISTER:   hit = match.duplicate;
      mbr_pkg::REQ_UNREGISTER: hit = match.handle_eq;
      default:                 hit = match.feedback_hit;
    endcase
  end

  always_comb begin
    unique case (state)
      S_SHIFT:                          rd_addr = idx_p1[IW-1:0];
      S_UPD_START, S_UPD_RD, S_UPD_EMIT: rd_addr = ptr;
      default:                          rd_addr = idx[IW-1:0];
    endcase
  end

  // memory writes: append on register, or move an entry down during unregister
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = new_entry;
    if (state == S_SCAN && scan_done && req.kind == mbr_pkg::REQ_REGISTER
        && count < DEPTH_C) begin
      wr_en = 1'b1;
    end else if (state == S_SHIFT && sh_vld) begin
      wr_en   = 1'b1;
      wr_addr = sh_idx;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ptr      <= '0;
      unknown  <= '0;
      budget   <= mbr_pkg::BUDGET_RESET;
      cmp_vld  <= 1'b0;
      sh_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        budget <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req.kind             <= mbr_pkg::req_kind_t'(s_tuser);
            req.motor_handle     <= s_tdata[7:0];
            req.can_id           <= s_tdata[36:8];
            req.master_nibble    <= s_tdata[40:37];
            req.transmit_id      <= s_tdata[69:41];
            req.frame_length     <= s_tdata[73:70];
            req.frame_first_byte <= s_tdata[81:74];
            res_status <= mbr_pkg::ST_OK;
            res_has    <= 1'b0;
            res_slot   <= '0;
            res_handle <= '0;
            idx        <= '0;
            cmp_vld    <= 1'b0;
            sh_vld     <= 1'b0;
            state <= (mbr_pkg::req_kind_t'(s_tuser) == mbr_pkg::REQ_UPDATE)
                   ? S_UPD_START : S_SCAN;
          end
        end

        // one read issued and one entry compared per cycle
        S_SCAN: begin
          if (cmp_vld && hit) begin
            cmp_vld <= 1'b0;
            unique case (req.kind)
              mbr_pkg::REQ_REGISTER: begin
                res_status <= mbr_pkg::ST_DUPLICATE;
                state      <= S_RESP;
              end
              mbr_pkg::REQ_UNREGISTER: begin
                idx   <= CW'(cmp_idx);
                state <= S_SHIFT;
              end
              default: begin
                res_has    <= 1'b1;
                res_slot   <= cmp_idx;
                res_handle <= rd_data.handle;
                state      <= S_RESP;
              end
            endcase
          end else if (scan_done) begin
            unique case (req.kind)
              mbr_pkg::REQ_REGISTER: begin
                if (count < DEPTH_C) begin
                  count <= count + CW'(1);
                end else begin
                  res_status <= mbr_pkg::ST_FULL;
                end
              end
              mbr_pkg::REQ_UNREGISTER: res_status <= mbr_pkg::ST_NOT_REG;
              default: begin
                unknown    <= unknown + 16'd1;
                res_status <= mbr_pkg::ST_NO_MATCH;
              end
            endcase
            state <= S_RESP;
          end else if (idx < count) begin
            cmp_vld <= 1'b1;
            cmp_idx <= idx[IW-1:0];
            idx     <= idx_p1;
          end else begin
            cmp_vld <= 1'b0;
          end
        end

        // read entry j+1, write it to j on the next cycle
        S_SHIFT: begin
          if (idx_p1 < count) begin
            sh_vld <= 1'b1;
            sh_idx <= idx[IW-1:0];
            idx    <= idx_p1;
          end else begin
            sh_vld <= 1'b0;
            if (!sh_vld) begin
              count <= count - CW'(1);
              if (ptr_ext >= count - CW'(1)) begin
                ptr <= '0;
              end
              state <= S_RESP;
            end
          end
        end

        S_RESP: begin
          if (out_free) begin
            m_tlast                  <= 1'b1;
            out_word.status          <= res_status;
            out_word.has_motor       <= res_has;
            out_word.slot_index      <= slot_wide[3:0];
            out_word.selected_handle <= res_handle;
            out_word.unknown_total   <= unknown;
            state                    <= S_IDLE;
          end
        end

        S_UPD_START: begin
          rem <= rem_calc;
          if (rem_calc == 5'd0) begin
            state <= S_RESP;
          end else begin
            if (ptr_ext >= count) begin
              ptr <= '0;
            end
            state <= S_UPD_RD;
          end
        end

        S_UPD_RD: begin
          state <= S_UPD_EMIT;
        end

        S_UPD_EMIT: begin
          if (out_free) begin
            m_tlast                  <= (rem == 5'd1);
            out_word.status          <= mbr_pkg::ST_OK;
            out_word.has_motor       <= 1'b1;
            out_word.slot_index      <= slot_wide[3:0];
            out_word.selected_handle <= rd_data.handle;
            out_word.unknown_total   <= unknown;
            rem <= rem - 5'd1;
            ptr <= (ptr_ext + CW'(1) == count) ? '0 : ptr + IW'(1);
            state <= (rem == 5'd1) ? S_IDLE : S_UPD_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (ptr_ext < count || ptr == '0))
    else $error("service pointer outside the table while idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CW'(wr_addr) <= count)
    else $error("table write beyond the filled part");

  a_unknown_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && unknown != $past(unknown)) |-> unknown == $past(unknown) + 16'd1)
    else $error("unknown frame count moved by more than one");

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for motor_bus_route_and_round_robin_unit
// depends on mbr_pkg and the unit; a table tracker class predicts every result word
// stream traffic with random gaps, one long output hold-off and budget changes while idle
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int POOL_SIZE = 32;
  localparam logic [28:0] ID_ONES = 29'h1FFFFFFF;

  typedef struct {
    mbr_pkg::out_word_t word;
    logic               last;
  } route_result_t;

  class motor_table_tracker;
    logic [7:0]  handles [TABLE_SLOTS];
    logic [28:0] feedback_ids [TABLE_SLOTS];
    logic [3:0]  nibbles [TABLE_SLOTS];
    logic [28:0] transmit_ids [TABLE_SLOTS];
    int unsigned entries;
    int unsigned next_slot;
    logic [15:0] unknown_frames;
    logic [4:0]  budget;
    route_result_t expected_results [$];
    int unsigned failures;

    function new();
      entries = 0;
      next_slot = 0;
      unknown_frames = '0;
      budget = mbr_pkg::BUDGET_RESET;
      failures = 0;
    endfunction

    function void expect_result(mbr_pkg::status_t st, bit has, int unsigned slot,
                                logic [7:0] handle, bit last);
      route_result_t r;
      r.word.status = st;
      r.word.has_motor = has;
      r.word.slot_index = has ? slot[3:0] : 4'd0;
      r.word.selected_handle = has ? handle : 8'd0;
      r.word.unknown_total = unknown_frames;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    function void note_request(mbr_pkg::request_t r);
      int hit;
      int unsigned n;
      hit = -1;
      case (r.kind)
        mbr_pkg::REQ_REGISTER: begin
          for (int i = 0; i < entries; i++)
            if (handles[i] == r.motor_handle || transmit_ids[i] == r.transmit_id ||
                (feedback_ids[i] == r.can_id && nibbles[i] == r.master_nibble))
              hit = i;
          // duplicate wins over a full table
          if (hit >= 0) begin
            expect_result(mbr_pkg::ST_DUPLICATE, 0, 0, 0, 1);
          end else if (entries >= TABLE_SLOTS) begin
            expect_result(mbr_pkg::ST_FULL, 0, 0, 0, 1);
          end else begin
            handles[entries] = r.motor_handle;
            feedback_ids[entries] = r.can_id;
            nibbles[entries] = r.master_nibble;
            transmit_ids[entries] = r.transmit_id;
            entries++;
            expect_result(mbr_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        mbr_pkg::REQ_UNREGISTER: begin
          for (int i = 0; i < entries; i++)
            if (hit < 0 && handles[i] == r.motor_handle) hit = i;
          if (hit >= 0) begin
            for (int j = hit; j + 1 < entries; j++) begin
              handles[j] = handles[j + 1];
              feedback_ids[j] = feedback_ids[j + 1];
              nibbles[j] = nibbles[j + 1];
              transmit_ids[j] = transmit_ids[j + 1];
            end
            entries--;
            if (next_slot >= entries) next_slot = 0;
            expect_result(mbr_pkg::ST_OK, 0, 0, 0, 1);
          end else begin
            expect_result(mbr_pkg::ST_NOT_REG, 0, 0, 0, 1);
          end
        end
        mbr_pkg::REQ_FEEDBACK: begin
          for (int i = 0; i < entries; i++)
            if (hit < 0 && feedback_ids[i] == r.can_id &&
                r.frame_length == mbr_pkg::FULL_FRAME_LEN &&
                r.frame_first_byte[3:0] == nibbles[i])
              hit = i;
          if (hit >= 0) begin
            expect_result(mbr_pkg::ST_OK, 1, hit, handles[hit], 1);
          end else begin
            unknown_frames++;
            expect_result(mbr_pkg::ST_NO_MATCH, 0, 0, 0, 1);
          end
        end
        mbr_pkg::REQ_UPDATE: begin
          n = (budget > mbr_pkg::MAX_BUDGET) ? mbr_pkg::MAX_BUDGET : budget;
          if (n > entries) n = entries;
          if (n == 0) begin
            expect_result(mbr_pkg::ST_OK, 0, 0, 0, 1);
          end else begin
            if (next_slot >= entries) next_slot = 0;
            for (int k = 0; k < n; k++) begin
              expect_result(mbr_pkg::ST_OK, 1, next_slot, handles[next_slot], k + 1 == n);
              next_slot = (next_slot + 1) % entries;
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [31:0] data, logic last);
      route_result_t want;
      mbr_pkg::out_word_t got;
      got = data;
      if (expected_results.size() == 0) begin
        $error("result %h with no request waiting", data);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.word.status, got.status);
      compare_field("has_motor", want.word.has_motor, got.has_motor);
      compare_field("slot_index", want.word.slot_index, got.slot_index);
      compare_field("selected_handle", want.word.selected_handle, got.selected_handle);
      compare_field("unknown_total", want.word.unknown_total, got.unknown_total);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  motor_table_tracker book = new();
  logic [7:0] handle_pool [POOL_SIZE];
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;
  bit hold_output = 1'b0;

  motor_bus_route_and_round_robin_unit #(.TABLE_DEPTH(TABLE_SLOTS)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic mbr_pkg::request_t make_request(mbr_pkg::req_kind_t kind,
                                                     logic [7:0] handle,
                                                     logic [28:0] cid, logic [3:0] nib,
                                                     logic [28:0] tid, logic [3:0] len,
                                                     logic [7:0] byte0);
    mbr_pkg::request_t r;
    r.kind = kind;
    r.motor_handle = handle;
    r.can_id = cid;
    r.master_nibble = nib;
    r.transmit_id = tid;
    r.frame_length = len;
    r.frame_first_byte = byte0;
    return r;
  endfunction

  // mostly well-formed requests against the live table, the rest noise
  function automatic mbr_pkg::request_t random_request(int unsigned w_reg,
                                                       int unsigned w_unreg,
                                                       int unsigned w_fb,
                                                       int unsigned w_upd);
    mbr_pkg::request_t r;
    int unsigned pick;
    int unsigned slot;
    r = make_request(mbr_pkg::REQ_UPDATE, handle_pool[$urandom_range(0, POOL_SIZE - 1)],
                     29'($urandom()), 4'($urandom()), 29'($urandom()),
                     4'($urandom_range(0, 15)), 8'($urandom()));
    slot = (book.entries != 0) ? $urandom_range(0, book.entries - 1) : 0;
    pick = $urandom_range(0, w_reg + w_unreg + w_fb + w_upd - 1);
    if (pick < w_reg) begin
      r.kind = mbr_pkg::REQ_REGISTER;
      if (book.entries != 0 && $urandom_range(0, 7) == 0) begin
        r.can_id = book.feedback_ids[slot];
        if ($urandom_range(0, 1) == 1) r.master_nibble = book.nibbles[slot];
      end
      if (book.entries != 0 && $urandom_range(0, 7) == 0)
        r.transmit_id = book.transmit_ids[slot];
    end else if (pick < w_reg + w_unreg) begin
      r.kind = mbr_pkg::REQ_UNREGISTER;
      if (book.entries != 0 && $urandom_range(0, 9) < 7) r.motor_handle = book.handles[slot];
    end else if (pick < w_reg + w_unreg + w_fb) begin
      r.kind = mbr_pkg::REQ_FEEDBACK;
      if (book.entries != 0 && $urandom_range(0, 3) != 0) begin
        r.can_id = book.feedback_ids[slot];
        r.frame_length = mbr_pkg::FULL_FRAME_LEN;
        r.frame_first_byte[3:0] = book.nibbles[slot];
        case ($urandom_range(0, 7))
          0: r.frame_length = 4'($urandom_range(0, 15));
          1: r.frame_first_byte[3:0] = 4'($urandom());
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_request(mbr_pkg::request_t r);
    int unsigned gap;
    if ($urandom_range(0, 11) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = r.kind;
    s_tdata = {6'd0, r.frame_first_byte, r.frame_length, r.transmit_id, r.master_nibble,
               r.can_id, r.motor_handle};
    do @(posedge clk); while (!s_tready);
    book.note_request(r);
  endtask

  task automatic write_budget(logic [4:0] value);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    book.budget = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_mix(int unsigned count);
    repeat (count) send_request(random_request(3, 2, 3, 2));
  endtask

  initial begin : result_taker
    int unsigned gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 11) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 18);
      // long stall so the unit backs up into its input
      if (hold_output) begin
        hold_output = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      book.check_result(m_tdata, m_tlast);
    end
  end

  initial begin : stimulus
    handle_pool[0] = 8'h00;
    handle_pool[1] = 8'hFF;
    for (int i = 2; i < POOL_SIZE; i++) handle_pool[i] = 8'($urandom());
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, budget at its reset value
    send_request(make_request(mbr_pkg::REQ_UPDATE, 8'h00, 29'd0, 4'd0, 29'd0, 4'd0, 8'h00));
    send_request(make_request(mbr_pkg::REQ_UNREGISTER, 8'hFF, 29'd0, 4'd0, 29'd0, 4'd0,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_FEEDBACK, 8'h00, ID_ONES, 4'd0, 29'd0, 4'd8,
                              8'hFF));
    send_request(make_request(mbr_pkg::REQ_REGISTER, 8'h00, 29'd0, 4'd0, 29'd0, 4'd0,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_REGISTER, 8'hFF, ID_ONES, 4'hF, ID_ONES, 4'hF,
                              8'hFF));
    send_request(make_request(mbr_pkg::REQ_REGISTER, 8'h00, 29'h55, 4'd3, 29'h66, 4'd0,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_REGISTER, 8'h11, 29'd0, 4'd0, 29'h77, 4'd0,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_REGISTER, 8'h12, 29'd0, 4'd5, ID_ONES, 4'd0,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_REGISTER, 8'h13, 29'd0, 4'd5, 29'h123, 4'd0,
                              8'h00));
    // same id, first slot whose nibble matches wins
    send_request(make_request(mbr_pkg::REQ_FEEDBACK, 8'h00, 29'd0, 4'd0, 29'd0, 4'd8,
                              8'hF5));
    send_request(make_request(mbr_pkg::REQ_FEEDBACK, 8'h00, 29'd0, 4'd0, 29'd0, 4'd8,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_FEEDBACK, 8'h00, ID_ONES, 4'd0, 29'd0, 4'd7,
                              8'h0F));
    send_request(make_request(mbr_pkg::REQ_FEEDBACK, 8'h00, ID_ONES, 4'd0, 29'd0, 4'hF,
                              8'hFF));
    send_request(make_request(mbr_pkg::REQ_FEEDBACK, 8'h00, ID_ONES, 4'd0, 29'd0, 4'd8,
                              8'h3F));
    send_request(make_request(mbr_pkg::REQ_UPDATE, 8'h00, 29'd0, 4'd0, 29'd0, 4'd0, 8'h00));
    send_request(make_request(mbr_pkg::REQ_UPDATE, 8'h00, 29'd0, 4'd0, 29'd0, 4'd0, 8'h00));
    // pointer would sit past the end after the removal and wraps to zero
    send_request(make_request(mbr_pkg::REQ_UNREGISTER, 8'h00, 29'd0, 4'd0, 29'd0, 4'd0,
                              8'h00));
    send_request(make_request(mbr_pkg::REQ_UPDATE, 8'h00, 29'd0, 4'd0, 29'd0, 4'd0, 8'h00));

    write_budget(5'd16);
    while (book.entries < TABLE_SLOTS) send_request(random_request(1, 0, 0, 0));
    send_request(make_request(mbr_pkg::REQ_REGISTER, book.handles[0], 29'h1, 4'd1, 29'h1,
                              4'd0, 8'h0));
    send_request(random_request(1, 0, 0, 0));
    send_request(random_request(1, 0, 0, 0));
    send_request(random_request(0, 0, 0, 1));
    run_mix(20);

    write_budget(5'd31);
    hold_output = 1'b1;
    send_request(random_request(0, 0, 0, 1));
    run_mix(20);

    write_budget(5'd0);
    run_mix(12);

    write_budget(5'($urandom_range(2, 15)));
    run_mix(15);

    write_budget(5'd1);
    run_mix(10);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/mbr_pkg.sv
hw/rtl/mbr_match.sv
hw/rtl/mbr_table.sv
hw/rtl/motor_bus_route_and_round_robin_unit.sv
bench/tb_top.sv
